/* hdl/esph_pkg.sv */
// Shared types, constants and helper functions for the event sphericity block.
`default_nettype none

package esph_pkg;

	localparam int MAX_PARTICLES_DEF = 64;
	localparam int JACOBI_SWEEPS_DEF = 6;

	localparam int MOM_W = 16;
	localparam int SPH_W = 17;
	localparam int SUM_W = 40;
	localparam int AQ_W  = 32;

	// Product steps per particle: xx, yy, zz, xy, xz, yz
	localparam logic [2:0] ACC_STEPS = 3'd6;
	// Largest right shift that brings a 40-bit norm below 2^32
	localparam int NSH_MAX = SUM_W - 32;
	// Iterations of the root and quotient units
	localparam logic [5:0] SQ_STEPS = 6'd32;
	localparam logic [4:0] DV_STEPS = 5'd31;

	localparam logic [SPH_W-1:0] SPH_MAX = 17'd98304;
	localparam logic signed [34:0] ONE_Q30 = 35'sd1073741824;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ACC,
		S_DECIDE,
		S_NPREP,
		S_NLOAD,
		S_NDIV,
		S_RCHK,
		S_RSQ1,
		S_RSQ2,
		S_RWSQ1,
		S_RWDV1,
		S_RTT,
		S_RWSQ2,
		S_RWDV2,
		S_RS,
		S_RTA,
		S_RC1,
		S_RC2,
		S_RC3,
		S_RC4,
		S_NEXT,
		S_FIN
	} state_t;

	// Rotation plane within one sweep
	typedef enum logic [1:0] {
		ROT_01,
		ROT_02,
		ROT_12
	} rot_t;

	// Attach a sign to a rounded product magnitude
	function automatic logic signed [34:0] apply_sign(input logic [32:0] mag, input logic neg);
		logic signed [34:0] v;
		v = $signed({2'b00, mag});
		return neg ? -v : v;
	endfunction

	// Limit a Q30 value to [-1, 1]
	function automatic logic signed [AQ_W-1:0] clamp_q30(input logic signed [34:0] v);
		logic signed [34:0] lo;
		lo = -ONE_Q30;
		if (v > ONE_Q30) begin
			return ONE_Q30[AQ_W-1:0];
		end else if (v < lo) begin
			return lo[AQ_W-1:0];
		end
		return v[AQ_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* hdl/event_sphericity.sv */
// Event sphericity: tensor accumulation and Jacobi eigen solve on one shared multiplier.
// A particle that does not end an event keeps busy high through the multiplier steps
// and one decide state; beyond MAX_PARTICLES it goes straight to the decide state.
// A final particle adds normalization (six quotients) and 3 * JACOBI_SWEEPS rotations;
// a rotation whose off-diagonal entry is already zero is skipped, and every other one
// runs the 32-step root unit and the 31-step quotient unit twice.
// Reset clears the sums, norm and particle count; results are not held off.
`default_nettype none

module event_sphericity #(
	parameter int MAX_PARTICLES = esph_pkg::MAX_PARTICLES_DEF,
	parameter int JACOBI_SWEEPS = esph_pkg::JACOBI_SWEEPS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic signed [esph_pkg::MOM_W-1:0] mom_x,
	input  wire logic signed [esph_pkg::MOM_W-1:0] mom_y,
	input  wire logic signed [esph_pkg::MOM_W-1:0] mom_z,
	input  wire logic                             last_particle,
	output logic                                  done,
	output logic [esph_pkg::SPH_W-1:0]            sphericity,
	output logic                                  degenerate
);
	import esph_pkg::*;

	localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
	localparam int SW_W  = $clog2(JACOBI_SWEEPS);

	state_t state_q, state_d;

	// Particle and accumulation state
	logic [MOM_W-1:0]        mag_q [3];
	logic                    neg_q [3];
	logic                    last_q;
	logic [2:0]              acc_cnt_q;
	logic [CNT_W-1:0]        cnt_q;
	logic signed [SUM_W-1:0] sum_q [6];
	logic [SUM_W-1:0]        norm_q;
	logic                    psign_q;
	logic                    acc_en_c;
	logic [2:0]              rd_idx;
	logic [2:0]              acc_idx;
	logic signed [SUM_W-1:0] sum_rd;
	logic signed [SUM_W:0]   sum_new;
	logic [SUM_W:0]          norm_new;
	logic signed [SUM_W:0]   prod_s;

	// Shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p_q;
	logic [63:0] rnd_full;
	logic [32:0] rnd_mag;

	// Normalization
	logic [31:0]      nsh_q, nsh_c;
	logic [3:0]       k_q, kk;
	logic [2:0]       e_q;
	logic             sneg_q;
	logic [SUM_W-1:0] smag_c, mmin_c, msh_c;

	// Matrix and rotation registers
	logic signed [AQ_W-1:0] a_q [6];
	rot_t                   rot_q;
	logic [SW_W-1:0]        sw_q;
	logic signed [AQ_W-1:0] app, aqq, apq, arp, arq;
	logic signed [32:0]     d_c;
	logic [32:0]            dn_c;
	logic [31:0]            ad_c;
	logic [31:0]            apqn_c, arpn_c, arqn_c;
	logic [30:0]            aa_c, arp_mag, arq_mag;
	logic                   dneg_q, aneg_q, tneg_q;
	logic [31:0]            ad_q;
	logic [30:0]            aa_q, tm_q, c_q, s_q;
	logic [63:0]            tmp_q;
	logic signed [34:0]     crp_q, srq_q, srp_q, tap_c, crq_c;

	// Root unit
	logic        sq_start;
	logic [63:0] sq_rad_in, sq_rad_q;
	logic [35:0] sq_rem_q, sq_rem2, sq_trial;
	logic [31:0] sq_root_q;
	logic [5:0]  sq_cnt_q;
	logic        sq_ge;

	// Quotient unit
	logic        dv_start;
	logic [61:0] dv_dvd_in;
	logic [33:0] dv_dsr_in, dv_dsr_q, dv_rem_q;
	logic [30:0] dv_low_q, dv_quo_q;
	logic [4:0]  dv_cnt_q;
	logic [34:0] dv_r2, dv_diff;
	logic        dv_ge;

	// Result
	logic             done_q, deg_q;
	logic [SPH_W-1:0] sph_q, fin_sph;
	logic [30:0]      v0, v1, v2, vmx;
	logic [32:0]      vtot, vrest;
	logic [34:0]      v3;
	logic [35:0]      vround;

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign sphericity = sph_q;
	assign degenerate = deg_q;

	assign acc_en_c = (cnt_q < CNT_W'(MAX_PARTICLES));
	assign acc_idx  = acc_cnt_q - 3'd1;
	assign rd_idx   = (state_q == S_ACC) ? acc_idx : e_q;
	assign sum_rd   = sum_q[rd_idx];

	// Round a Q30 product half away from zero
	assign rnd_full = mul_p_q + 64'h0000_0000_2000_0000;
	assign rnd_mag  = rnd_full[62:30];

	// Accumulate with saturation
	always_comb begin
		prod_s = psign_q ? -$signed({10'b0, mul_p_q[30:0]}) : $signed({10'b0, mul_p_q[30:0]});
		sum_new = $signed({sum_rd[SUM_W-1], sum_rd}) + prod_s;
		if (sum_new > $signed({2'b00, {(SUM_W-1){1'b1}}})) begin
			sum_new = $signed({2'b00, {(SUM_W-1){1'b1}}});
		end else if (sum_new < $signed({2'b11, {(SUM_W-1){1'b0}}})) begin
			sum_new = $signed({2'b11, {(SUM_W-1){1'b0}}});
		end
		norm_new = {1'b0, norm_q} + {10'b0, mul_p_q[30:0]};
		if (norm_new[SUM_W]) begin
			norm_new = {1'b0, {SUM_W{1'b1}}};
		end
	end

	// Find the norm shift and normalization operand
	always_comb begin
		kk = '0;
		for (int i = NSH_MAX; i >= 0; i--) begin
			if ((norm_q >> i) < 40'h01_0000_0000) begin
				kk = 4'(i);
			end
		end
		nsh_c  = 32'(norm_q >> kk);
		smag_c = sum_rd[SUM_W-1] ? SUM_W'(-sum_rd) : SUM_W'(sum_rd);
		mmin_c = (smag_c > norm_q) ? norm_q : smag_c;
		msh_c  = mmin_c >> k_q;
	end

	// Select the entries of the current rotation plane
	always_comb begin
		unique case (rot_q)
			ROT_01: begin
				app = a_q[0]; aqq = a_q[1]; apq = a_q[3]; arp = a_q[4]; arq = a_q[5];
			end
			ROT_02: begin
				app = a_q[0]; aqq = a_q[2]; apq = a_q[4]; arp = a_q[3]; arq = a_q[5];
			end
			ROT_12: begin
				app = a_q[1]; aqq = a_q[2]; apq = a_q[5]; arp = a_q[3]; arq = a_q[4];
			end
			default: begin
				app = '0; aqq = '0; apq = '0; arp = '0; arq = '0;
			end
		endcase
		d_c     = $signed({aqq[AQ_W-1], aqq}) - $signed({app[AQ_W-1], app});
		dn_c    = -d_c;
		ad_c    = d_c[32] ? dn_c[31:0] : d_c[31:0];
		apqn_c  = -apq;
		arpn_c  = -arp;
		arqn_c  = -arq;
		aa_c    = apq[AQ_W-1] ? apqn_c[30:0] : apq[30:0];
		arp_mag = arp[AQ_W-1] ? arpn_c[30:0] : arp[30:0];
		arq_mag = arq[AQ_W-1] ? arqn_c[30:0] : arq[30:0];
		tap_c   = apply_sign(rnd_mag, tneg_q ^ aneg_q);
		crq_c   = apply_sign(rnd_mag, arq[AQ_W-1]);
	end

	// Form the result from the diagonal
	always_comb begin
		v0 = a_q[0][AQ_W-1] ? 31'd0 : a_q[0][30:0];
		v1 = a_q[1][AQ_W-1] ? 31'd0 : a_q[1][30:0];
		v2 = a_q[2][AQ_W-1] ? 31'd0 : a_q[2][30:0];
		vmx = (v0 > v1) ? v0 : v1;
		if (v2 > vmx) begin
			vmx = v2;
		end
		vtot   = 33'(v0) + 33'(v1) + 33'(v2);
		vrest  = vtot - 33'(vmx);
		v3     = {1'b0, vrest, 1'b0} + 35'(vrest);
		vround = 36'(v3) + 36'h0_0000_4000;
		if (vround[35:15] > 21'(SPH_MAX)) begin
			fin_sph = SPH_MAX;
		end else begin
			fin_sph = vround[31:15];
		end
	end

	// Sequence the shared units
	always_comb begin
		state_d   = state_q;
		sq_start  = 1'b0;
		sq_rad_in = '0;
		dv_start  = 1'b0;
		dv_dvd_in = '0;
		dv_dsr_in = '0;
		mul_a     = '0;
		mul_b     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = acc_en_c ? S_ACC : S_DECIDE;
				end
			end
			S_ACC: begin
				case (acc_cnt_q)
					3'd0: begin mul_a = 32'(mag_q[0]); mul_b = 32'(mag_q[0]); end
					3'd1: begin mul_a = 32'(mag_q[1]); mul_b = 32'(mag_q[1]); end
					3'd2: begin mul_a = 32'(mag_q[2]); mul_b = 32'(mag_q[2]); end
					3'd3: begin mul_a = 32'(mag_q[0]); mul_b = 32'(mag_q[1]); end
					3'd4: begin mul_a = 32'(mag_q[0]); mul_b = 32'(mag_q[2]); end
					3'd5: begin mul_a = 32'(mag_q[1]); mul_b = 32'(mag_q[2]); end
					default: begin mul_a = '0; mul_b = '0; end
				endcase
				if (acc_cnt_q == ACC_STEPS) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (!last_q || norm_q == '0) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_NPREP;
				end
			end
			S_NPREP: state_d = S_NLOAD;
			S_NLOAD: begin
				dv_start  = 1'b1;
				dv_dvd_in = {msh_c[31:0], 30'b0};
				dv_dsr_in = {2'b00, nsh_q};
				state_d   = S_NDIV;
			end
			S_NDIV: begin
				if (dv_cnt_q == '0) begin
					state_d = (e_q == 3'd5) ? S_RCHK : S_NLOAD;
				end
			end
			S_RCHK: begin
				if (apq == '0) begin
					state_d = S_NEXT;
				end else begin
					mul_a   = ad_c;
					mul_b   = ad_c;
					state_d = S_RSQ1;
				end
			end
			S_RSQ1: begin
				mul_a   = {1'b0, aa_q};
				mul_b   = {1'b0, aa_q};
				state_d = S_RSQ2;
			end
			S_RSQ2: begin
				sq_start  = 1'b1;
				sq_rad_in = tmp_q + {mul_p_q[61:0], 2'b00};
				state_d   = S_RWSQ1;
			end
			S_RWSQ1: begin
				if (sq_cnt_q == '0) begin
					dv_start  = 1'b1;
					dv_dvd_in = {aa_q, 31'b0};
					dv_dsr_in = 34'(ad_q) + 34'(sq_root_q);
					state_d   = S_RWDV1;
				end
			end
			S_RWDV1: begin
				if (dv_cnt_q == '0) begin
					mul_a   = {1'b0, dv_quo_q};
					mul_b   = {1'b0, dv_quo_q};
					state_d = S_RTT;
				end
			end
			S_RTT: begin
				sq_start  = 1'b1;
				sq_rad_in = 64'h1000_0000_0000_0000 + mul_p_q;
				state_d   = S_RWSQ2;
			end
			S_RWSQ2: begin
				if (sq_cnt_q == '0) begin
					dv_start  = 1'b1;
					dv_dvd_in = 62'h1000_0000_0000_0000;
					dv_dsr_in = 34'(sq_root_q);
					state_d   = S_RWDV2;
				end
			end
			S_RWDV2: begin
				if (dv_cnt_q == '0) begin
					mul_a   = {1'b0, tm_q};
					mul_b   = {1'b0, dv_quo_q};
					state_d = S_RS;
				end
			end
			S_RS: begin
				mul_a   = {1'b0, tm_q};
				mul_b   = {1'b0, aa_q};
				state_d = S_RTA;
			end
			S_RTA: begin
				mul_a   = {1'b0, c_q};
				mul_b   = {1'b0, arp_mag};
				state_d = S_RC1;
			end
			S_RC1: begin
				mul_a   = {1'b0, s_q};
				mul_b   = {1'b0, arq_mag};
				state_d = S_RC2;
			end
			S_RC2: begin
				mul_a   = {1'b0, s_q};
				mul_b   = {1'b0, arp_mag};
				state_d = S_RC3;
			end
			S_RC3: begin
				mul_a   = {1'b0, c_q};
				mul_b   = {1'b0, arq_mag};
				state_d = S_RC4;
			end
			S_RC4: state_d = S_NEXT;
			S_NEXT: begin
				if (rot_q == ROT_12 && sw_q == SW_W'(JACOBI_SWEEPS - 1)) begin
					state_d = S_FIN;
				end else begin
					state_d = S_RCHK;
				end
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Advance counters and sums; clear them at the end of an event
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_cnt_q <= '0;
			cnt_q     <= '0;
			norm_q    <= '0;
			e_q       <= '0;
			rot_q     <= ROT_01;
			sw_q      <= '0;
			done_q    <= 1'b0;
			for (int i = 0; i < 6; i++) begin
				sum_q[i] <= '0;
			end
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					acc_cnt_q <= '0;
					if (start && acc_en_c) begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_ACC: begin
					acc_cnt_q <= acc_cnt_q + 3'd1;
					if (acc_cnt_q != 3'd0) begin
						sum_q[acc_idx] <= sum_new[SUM_W-1:0];
						if (acc_idx < 3'd3) begin
							norm_q <= norm_new[SUM_W-1:0];
						end
					end
				end
				S_DECIDE: begin
					if (last_q && norm_q == '0) begin
						done_q <= 1'b1;
						cnt_q  <= '0;
						for (int i = 0; i < 6; i++) begin
							sum_q[i] <= '0;
						end
					end
				end
				S_NPREP: e_q <= '0;
				S_NDIV: begin
					if (dv_cnt_q == '0) begin
						e_q   <= e_q + 3'd1;
						rot_q <= ROT_01;
						sw_q  <= '0;
					end
				end
				S_NEXT: begin
					unique case (rot_q)
						ROT_01: rot_q <= ROT_02;
						ROT_02: rot_q <= ROT_12;
						default: begin
							rot_q <= ROT_01;
							sw_q  <= sw_q + SW_W'(1);
						end
					endcase
				end
				S_FIN: begin
					done_q <= 1'b1;
					cnt_q  <= '0;
					norm_q <= '0;
					for (int i = 0; i < 6; i++) begin
						sum_q[i] <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// Multiply every cycle; the sequencer picks the operands
	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
	end

	// Capture the datapath values of each step
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					mag_q[0] <= mom_x[MOM_W-1] ? MOM_W'(-mom_x) : mom_x;
					mag_q[1] <= mom_y[MOM_W-1] ? MOM_W'(-mom_y) : mom_y;
					mag_q[2] <= mom_z[MOM_W-1] ? MOM_W'(-mom_z) : mom_z;
					neg_q[0] <= mom_x[MOM_W-1];
					neg_q[1] <= mom_y[MOM_W-1];
					neg_q[2] <= mom_z[MOM_W-1];
					last_q   <= last_particle;
				end
			end
			S_ACC: begin
				case (acc_cnt_q)
					3'd3:    psign_q <= neg_q[0] ^ neg_q[1];
					3'd4:    psign_q <= neg_q[0] ^ neg_q[2];
					3'd5:    psign_q <= neg_q[1] ^ neg_q[2];
					default: psign_q <= 1'b0;
				endcase
			end
			S_DECIDE: begin
				sph_q <= '0;
				deg_q <= 1'b1;
			end
			S_NPREP: begin
				nsh_q <= nsh_c;
				k_q   <= kk;
			end
			S_NLOAD: sneg_q <= sum_rd[SUM_W-1];
			S_NDIV: begin
				if (dv_cnt_q == '0) begin
					a_q[e_q] <= clamp_q30(apply_sign({2'b00, dv_quo_q}, sneg_q));
				end
			end
			S_RCHK: begin
				dneg_q <= d_c[32];
				ad_q   <= ad_c;
				aa_q   <= aa_c;
				aneg_q <= apq[AQ_W-1];
			end
			S_RSQ1: tmp_q <= mul_p_q;
			S_RWDV1: begin
				tm_q   <= dv_quo_q;
				tneg_q <= dneg_q ^ aneg_q;
			end
			S_RWDV2: c_q <= dv_quo_q;
			S_RS: s_q <= rnd_mag[30:0];
			S_RTA: begin
				unique case (rot_q)
					ROT_01: begin
						a_q[0] <= clamp_q30(35'(app) - tap_c);
						a_q[1] <= clamp_q30(35'(aqq) + tap_c);
						a_q[3] <= '0;
					end
					ROT_02: begin
						a_q[0] <= clamp_q30(35'(app) - tap_c);
						a_q[2] <= clamp_q30(35'(aqq) + tap_c);
						a_q[4] <= '0;
					end
					default: begin
						a_q[1] <= clamp_q30(35'(app) - tap_c);
						a_q[2] <= clamp_q30(35'(aqq) + tap_c);
						a_q[5] <= '0;
					end
				endcase
			end
			S_RC1: crp_q <= apply_sign(rnd_mag, arp[AQ_W-1]);
			S_RC2: srq_q <= apply_sign(rnd_mag, tneg_q ^ arq[AQ_W-1]);
			S_RC3: srp_q <= apply_sign(rnd_mag, tneg_q ^ arp[AQ_W-1]);
			S_RC4: begin
				unique case (rot_q)
					ROT_01: begin
						a_q[4] <= clamp_q30(crp_q - srq_q);
						a_q[5] <= clamp_q30(srp_q + crq_c);
					end
					ROT_02: begin
						a_q[3] <= clamp_q30(crp_q - srq_q);
						a_q[5] <= clamp_q30(srp_q + crq_c);
					end
					default: begin
						a_q[3] <= clamp_q30(crp_q - srq_q);
						a_q[4] <= clamp_q30(srp_q + crq_c);
					end
				endcase
			end
			S_FIN: begin
				sph_q <= fin_sph;
				deg_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// Root unit: two radicand bits per cycle
	assign sq_rem2  = {sq_rem_q[33:0], sq_rad_q[63:62]};
	assign sq_trial = {2'b00, sq_root_q, 2'b01};
	assign sq_ge    = (sq_rem2 >= sq_trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_cnt_q  <= '0;
			sq_rad_q  <= '0;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_start) begin
			sq_cnt_q  <= SQ_STEPS;
			sq_rad_q  <= sq_rad_in;
			sq_rem_q  <= '0;
			sq_root_q <= '0;
		end else if (sq_cnt_q != '0) begin
			sq_cnt_q  <= sq_cnt_q - 6'd1;
			sq_rad_q  <= {sq_rad_q[61:0], 2'b00};
			sq_rem_q  <= sq_ge ? (sq_rem2 - sq_trial) : sq_rem2;
			sq_root_q <= {sq_root_q[30:0], sq_ge};
		end
	end

	// Quotient unit: one quotient bit per cycle
	assign dv_r2   = {dv_rem_q, dv_low_q[30]};
	assign dv_ge   = (dv_r2 >= {1'b0, dv_dsr_q});
	assign dv_diff = dv_r2 - {1'b0, dv_dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_cnt_q <= '0;
			dv_rem_q <= '0;
			dv_low_q <= '0;
			dv_dsr_q <= '0;
			dv_quo_q <= '0;
		end else if (dv_start) begin
			dv_cnt_q <= DV_STEPS;
			dv_rem_q <= {3'b000, dv_dvd_in[61:31]};
			dv_low_q <= dv_dvd_in[30:0];
			dv_dsr_q <= dv_dsr_in;
			dv_quo_q <= '0;
		end else if (dv_cnt_q != '0) begin
			dv_cnt_q <= dv_cnt_q - 5'd1;
			dv_rem_q <= dv_ge ? dv_diff[33:0] : dv_r2[33:0];
			dv_low_q <= {dv_low_q[29:0], 1'b0};
			dv_quo_q <= {dv_quo_q[29:0], dv_ge};
		end
	end

	// Checks
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && degenerate) |-> (sphericity == '0))
		else $error("degenerate result with nonzero sphericity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sphericity <= SPH_MAX))
		else $error("sphericity out of range");

	a_units_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> (sq_cnt_q == '0 && dv_cnt_q == '0))
		else $error("arithmetic unit running while idle");

endmodule

`default_nettype wire
